>>> hw/rtl/ilu_pkg.sv
`default_nettype none
package ilu_pkg;

   localparam int IQ_W   = 36;
   localparam int QBITS  = 32;
   localparam int DEN_W  = 35;
   localparam int REM_W  = 63;
   localparam int CMP_W  = 67;
   localparam int ISTG   = 10;

   typedef logic signed [IQ_W-1:0] iq_type;
   typedef logic signed [31:0]     q32_type;
   typedef logic signed [71:0]     prod_type;

   localparam iq_type  INT_LIM = 36'sh4_0000_0000;
   localparam iq_type  ONE_Q28 = 36'sh0_1000_0000;
   localparam q32_type OUT_MAX = 32'sh7fff_ffff;
   localparam q32_type OUT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      CSR_FOCAL_X,
      CSR_FOCAL_Y,
      CSR_PRINCIPAL,
      CSR_K1,
      CSR_K2,
      CSR_K3,
      CSR_P1,
      CSR_P2
   } csr_index_type;

   typedef struct packed {
      iq_type val;
      logic   sat;
   } iqs_type;

   typedef struct packed {
      q32_type x0;
      q32_type y0;
      q32_type xu;
      q32_type yu;
      logic    f;
      logic    done;
   } carry_type;

   typedef struct packed {
      logic             neg;
      logic             bad;
      logic             nz;
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [REM_W-1:0] rem;
      logic [QBITS-1:0] quo;
   } div_lane_type;

   function automatic iqs_type sadd_fn(iq_type a, iq_type b);
      logic signed [IQ_W:0] s;
      iqs_type o;
      s = (IQ_W+1)'(a) + (IQ_W+1)'(b);
      o.sat = 1'b0;
      o.val = s[IQ_W-1:0];
      if (s > (IQ_W+1)'(INT_LIM)) begin
         o.val = INT_LIM;
         o.sat = 1'b1;
      end else if (s < -((IQ_W+1)'(INT_LIM))) begin
         o.val = -INT_LIM;
         o.sat = 1'b1;
      end
      return o;
   endfunction

   function automatic iqs_type rnd_fn(prod_type p, logic sh24);
      logic [71:0] m;
      logic [71:0] r;
      iq_type mag;
      iqs_type o;
      m = p[71] ? $unsigned(-p) : $unsigned(p);
      r = sh24 ? (m >> 24) + 72'(m[23]) : (m >> 28) + 72'(m[27]);
      o.sat = r > 72'(INT_LIM);
      mag = o.sat ? INT_LIM : iq_type'(r[IQ_W-1:0]);
      o.val = p[71] ? -mag : mag;
      return o;
   endfunction

   function automatic carry_type add_flag(carry_type c, logic fl);
      carry_type o;
      o = c;
      o.f = c.f | (fl & ~c.done);
      return o;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ilu_div.sv
`default_nettype none
module ilu_div #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ilu_pkg::iq_type      num_x,
   input  ilu_pkg::iq_type      num_y,
   input  ilu_pkg::iq_type      den_x,
   input  ilu_pkg::iq_type      den_y,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output ilu_pkg::q32_type     quot_x,
   output ilu_pkg::q32_type     quot_y,
   output logic                 sat,
   output logic [SIDE_W-1:0]    side_out
);
   import ilu_pkg::*;

   localparam int NS = QBITS + 2;

   div_lane_type      lane_ff [2][NS];
   div_lane_type      lane_in [2][NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic              v_ff [NS];
   iq_type            num_a [2];
   iq_type            den_a [2];
   iq_type            abs_v [2];
   q32_type           res_in [2];
   logic              sat_in [2];
   logic              out_valid_ff;
   q32_type           quot_x_ff;
   q32_type           quot_y_ff;
   logic              sat_ff;
   logic [SIDE_W-1:0] side_out_ff;

   always_comb begin
      div_lane_type e;
      logic [CMP_W-1:0] rem_w;
      logic [CMP_W-1:0] den_w;
      num_a[0] = num_x;
      num_a[1] = num_y;
      den_a[0] = den_x;
      den_a[1] = den_y;
      for (int l = 0; l < 2; l++) begin
         abs_v[l] = num_a[l][IQ_W-1] ? -num_a[l] : num_a[l];
         lane_in[l][0].neg = num_a[l][IQ_W-1];
         lane_in[l][0].nz  = num_a[l] != '0;
         lane_in[l][0].bad = den_a[l][IQ_W-1] || (den_a[l] == '0);
         lane_in[l][0].ovf = 1'b0;
         lane_in[l][0].den = den_a[l][DEN_W-1:0];
         lane_in[l][0].rem = REM_W'(abs_v[l][DEN_W-1:0]);
         lane_in[l][0].quo = '0;

         e = lane_ff[l][0];
         lane_in[l][1] = e;
         lane_in[l][1].ovf = ((CMP_W'(e.rem)) << 28) >= {e.den, 32'b0};
         lane_in[l][1].rem = e.rem << 28;

         for (int k = 2; k < NS; k++) begin
            e = lane_ff[l][k-1];
            lane_in[l][k] = e;
            rem_w = CMP_W'(e.rem);
            den_w = (CMP_W'(e.den)) << (NS - 1 - k);
            if (rem_w >= den_w) begin
               lane_in[l][k].rem = REM_W'(rem_w - den_w);
               lane_in[l][k].quo[NS-1-k] = 1'b1;
            end
         end

         e = lane_ff[l][NS-1];
         sat_in[l] = 1'b1;
         if (e.bad) begin
            res_in[l] = e.neg ? OUT_MIN : (e.nz ? OUT_MAX : '0);
         end else if (e.ovf) begin
            res_in[l] = e.neg ? OUT_MIN : OUT_MAX;
         end else if (!e.neg) begin
            sat_in[l] = e.quo[QBITS-1];
            res_in[l] = e.quo[QBITS-1] ? OUT_MAX : q32_type'(e.quo);
         end else begin
            sat_in[l] = e.quo[QBITS-1] && (e.quo[QBITS-2:0] != '0);
            res_in[l] = sat_in[l] ? OUT_MIN : -q32_type'(e.quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         out_valid_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff    <= lane_in;
         side_ff[0] <= side_in;
         for (int k = 1; k < NS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         quot_x_ff   <= res_in[0];
         quot_y_ff   <= res_in[1];
         sat_ff      <= sat_in[0] | sat_in[1];
         side_out_ff <= side_ff[NS-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign quot_x    = quot_x_ff;
   assign quot_y    = quot_y_ff;
   assign sat       = sat_ff;
   assign side_out  = side_out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/iterative_lens_undistort.sv
// Throughput: one point per cycle; every iteration is unrolled into its own stages
// (10 arithmetic stages plus a 35-stage radix-2 divider pair).
// A two-entry output buffer keeps req_ready registered; stalls freeze all stages.
// Reset: synchronous, clears all valid bits; focal lengths load 1000.0, others 0.
`default_nettype none
module iterative_lens_undistort #(
   parameter int ITERATIONS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_pixel_u,
   input  logic signed [31:0]     req_pixel_v,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_norm_x,
   output logic signed [31:0]     rsp_norm_y,
   output logic                   rsp_saturated,
   input  logic                   csr_wr_en,
   input  ilu_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wr_data
);
   import ilu_pkg::*;

   logic [31:0]        focal_x_ff;
   logic [31:0]        focal_y_ff;
   logic [63:0]        principal_ff;
   logic signed [31:0] k1_ff;
   logic signed [31:0] k2_ff;
   logic signed [31:0] k3_ff;
   logic signed [31:0] p1_ff;
   logic signed [31:0] p2_ff;

   iq_type k1_w, k2_w, k3_w, p1_w, p2_w;

   logic      adv;
   carry_type itc [ITERATIONS+1];
   logic      itv [ITERATIONS+1];

   logic    init_valid;
   q32_type init_x;
   q32_type init_y;
   logic    init_sat;
   logic    init_side;

   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   logic      out_load, skid_load;
   carry_type out_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= 32'd65536000;
         focal_y_ff   <= 32'd65536000;
         principal_ff <= '0;
         k1_ff        <= '0;
         k2_ff        <= '0;
         k3_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOCAL_X:   focal_x_ff   <= csr_wr_data[31:0];
            CSR_FOCAL_Y:   focal_y_ff   <= csr_wr_data[31:0];
            CSR_PRINCIPAL: principal_ff <= csr_wr_data;
            CSR_K1:        k1_ff        <= csr_wr_data[31:0];
            CSR_K2:        k2_ff        <= csr_wr_data[31:0];
            CSR_K3:        k3_ff        <= csr_wr_data[31:0];
            CSR_P1:        p1_ff        <= csr_wr_data[31:0];
            CSR_P2:        p2_ff        <= csr_wr_data[31:0];
            default:       ;
         endcase
      end
   end

   assign k1_w = iq_type'(k1_ff);
   assign k2_w = iq_type'(k2_ff);
   assign k3_w = iq_type'(k3_ff);
   assign p1_w = iq_type'(p1_ff);
   assign p2_w = iq_type'(p2_ff);

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   ilu_div #(.SIDE_W(1)) u_init_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid && req_ready),
      .num_x    (iq_type'(req_pixel_u) - iq_type'($signed(principal_ff[63:32]))),
      .num_y    (iq_type'(req_pixel_v) - iq_type'($signed(principal_ff[31:0]))),
      .den_x    (iq_type'($signed({1'b0, focal_x_ff}))),
      .den_y    (iq_type'($signed({1'b0, focal_y_ff}))),
      .side_in  (1'b0),
      .out_valid(init_valid),
      .quot_x   (init_x),
      .quot_y   (init_y),
      .sat      (init_sat),
      .side_out (init_side)
   );

   assign itv[0] = init_valid;
   assign itc[0] = '{x0: init_x, y0: init_y, xu: init_x, yu: init_y,
                     f: init_sat | init_side, done: 1'b0};

   for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_iter
      carry_type c_ff [ISTG];
      carry_type c_in [ISTG];
      logic      v_ff [ISTG];
      logic      fl_in [ISTG];

      prod_type pxx_in, pyy_in, pxy_in, pxx_ff, pyy_ff, pxy_ff;
      iqs_type  xx_in, yy_in, xy_in;
      iq_type   xx_ff, yy_ff, xy_ff;
      iqs_type  r2_in, xx2_in, yy2_in;
      iq_type   r2_ff, xx2_ff, yy2_ff, xy3_ff;
      prod_type pr4_in, pk1_in, pax_in, pby_in;
      iqs_type  sx_in, sy_in;
      prod_type pr4_ff, pk1_ff, pax_ff, pby_ff;
      iq_type   sx_ff, sy_ff, r2b_ff;
      iqs_type  r4_in, t1_in, ax_in, by_in;
      prod_type pbx_in, pay_in;
      iq_type   r4_ff, t1_ff, ax_ff, by_ff, r2c_ff;
      prod_type pbx_ff, pay_ff;
      prod_type pr6_in, pk2_in;
      iqs_type  rad1_in, bx_in, ay_in, ax2_in, by2_in;
      prod_type pr6_ff, pk2_ff;
      iq_type   rad1_ff, bx_ff, ay_ff, ax2_ff, by2_ff;
      iqs_type  r6_in, t2_in, tx_in, ty_in;
      iq_type   r6_ff, t2_ff, tx_ff, ty_ff, rad1b_ff;
      prod_type pk3_in, pk3_ff;
      iqs_type  rad2_in, nx_in, ny_in;
      iq_type   rad2_ff, nx_ff, ny_ff;
      iqs_type  t3_in;
      iq_type   t3_ff, rad2b_ff, nx9_ff, ny9_ff;
      iqs_type  rad_in;
      iq_type   rad_ff, nx10_ff, ny10_ff;
      logic     rad_bad_ff;

      logic      dv;
      q32_type   dqx, dqy;
      logic      dsat;
      carry_type dc;
      logic      dbad;
      carry_type nc;

      always_comb begin
         pxx_in = prod_type'(itc[gi].xu) * prod_type'(itc[gi].xu);
         pyy_in = prod_type'(itc[gi].yu) * prod_type'(itc[gi].yu);
         pxy_in = prod_type'(itc[gi].xu) * prod_type'(itc[gi].yu);
         fl_in[0] = 1'b0;

         xx_in = rnd_fn(pxx_ff, 1'b0);
         yy_in = rnd_fn(pyy_ff, 1'b0);
         xy_in = rnd_fn(pxy_ff, 1'b0);
         fl_in[1] = xx_in.sat | yy_in.sat | xy_in.sat;

         r2_in  = sadd_fn(xx_ff, yy_ff);
         xx2_in = sadd_fn(xx_ff, xx_ff);
         yy2_in = sadd_fn(yy_ff, yy_ff);
         fl_in[2] = r2_in.sat | xx2_in.sat | yy2_in.sat;

         pr4_in = prod_type'(r2_ff) * prod_type'(r2_ff);
         pk1_in = prod_type'(k1_w) * prod_type'(r2_ff);
         pax_in = prod_type'(p1_w) * prod_type'(xy3_ff);
         pby_in = prod_type'(p2_w) * prod_type'(xy3_ff);
         sx_in  = sadd_fn(r2_ff, xx2_ff);
         sy_in  = sadd_fn(r2_ff, yy2_ff);
         fl_in[3] = sx_in.sat | sy_in.sat;

         r4_in  = rnd_fn(pr4_ff, 1'b0);
         t1_in  = rnd_fn(pk1_ff, 1'b1);
         ax_in  = rnd_fn(pax_ff, 1'b1);
         by_in  = rnd_fn(pby_ff, 1'b1);
         pbx_in = prod_type'(p2_w) * prod_type'(sx_ff);
         pay_in = prod_type'(p1_w) * prod_type'(sy_ff);
         fl_in[4] = r4_in.sat | t1_in.sat | ax_in.sat | by_in.sat;

         pr6_in  = prod_type'(r4_ff) * prod_type'(r2c_ff);
         pk2_in  = prod_type'(k2_w) * prod_type'(r4_ff);
         rad1_in = sadd_fn(ONE_Q28, t1_ff);
         bx_in   = rnd_fn(pbx_ff, 1'b1);
         ay_in   = rnd_fn(pay_ff, 1'b1);
         ax2_in  = sadd_fn(ax_ff, ax_ff);
         by2_in  = sadd_fn(by_ff, by_ff);
         fl_in[5] = rad1_in.sat | bx_in.sat | ay_in.sat | ax2_in.sat | by2_in.sat;

         r6_in = rnd_fn(pr6_ff, 1'b0);
         t2_in = rnd_fn(pk2_ff, 1'b1);
         tx_in = sadd_fn(ax2_ff, bx_ff);
         ty_in = sadd_fn(ay_ff, by2_ff);
         fl_in[6] = r6_in.sat | t2_in.sat | tx_in.sat | ty_in.sat;

         pk3_in  = prod_type'(k3_w) * prod_type'(r6_ff);
         rad2_in = sadd_fn(rad1b_ff, t2_ff);
         nx_in   = sadd_fn(iq_type'(c_ff[6].x0), -tx_ff);
         ny_in   = sadd_fn(iq_type'(c_ff[6].y0), -ty_ff);
         fl_in[7] = rad2_in.sat | nx_in.sat | ny_in.sat;

         t3_in = rnd_fn(pk3_ff, 1'b1);
         fl_in[8] = t3_in.sat;

         rad_in = sadd_fn(rad2b_ff, t3_ff);
         fl_in[9] = rad_in.sat;

         c_in[0] = itc[gi];
         for (int k = 1; k < ISTG; k++) begin
            c_in[k] = add_flag(c_ff[k-1], fl_in[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int k = 0; k < ISTG; k++) begin
               v_ff[k] <= 1'b0;
            end
         end else if (adv) begin
            v_ff[0] <= itv[gi];
            for (int k = 1; k < ISTG; k++) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c_ff <= c_in;
            pxx_ff <= pxx_in;
            pyy_ff <= pyy_in;
            pxy_ff <= pxy_in;
            xx_ff <= xx_in.val;
            yy_ff <= yy_in.val;
            xy_ff <= xy_in.val;
            r2_ff  <= r2_in.val;
            xx2_ff <= xx2_in.val;
            yy2_ff <= yy2_in.val;
            xy3_ff <= xy_ff;
            pr4_ff <= pr4_in;
            pk1_ff <= pk1_in;
            pax_ff <= pax_in;
            pby_ff <= pby_in;
            sx_ff  <= sx_in.val;
            sy_ff  <= sy_in.val;
            r2b_ff <= r2_ff;
            r4_ff  <= r4_in.val;
            t1_ff  <= t1_in.val;
            ax_ff  <= ax_in.val;
            by_ff  <= by_in.val;
            pbx_ff <= pbx_in;
            pay_ff <= pay_in;
            r2c_ff <= r2b_ff;
            pr6_ff  <= pr6_in;
            pk2_ff  <= pk2_in;
            rad1_ff <= rad1_in.val;
            bx_ff   <= bx_in.val;
            ay_ff   <= ay_in.val;
            ax2_ff  <= ax2_in.val;
            by2_ff  <= by2_in.val;
            r6_ff    <= r6_in.val;
            t2_ff    <= t2_in.val;
            tx_ff    <= tx_in.val;
            ty_ff    <= ty_in.val;
            rad1b_ff <= rad1_ff;
            pk3_ff  <= pk3_in;
            rad2_ff <= rad2_in.val;
            nx_ff   <= nx_in.val;
            ny_ff   <= ny_in.val;
            t3_ff    <= t3_in.val;
            rad2b_ff <= rad2_ff;
            nx9_ff   <= nx_ff;
            ny9_ff   <= ny_ff;
            rad_ff     <= rad_in.val;
            rad_bad_ff <= rad_in.val[IQ_W-1] || (rad_in.val == '0);
            nx10_ff    <= nx9_ff;
            ny10_ff    <= ny9_ff;
         end
      end

      ilu_div #(.SIDE_W($bits(carry_type) + 1)) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (v_ff[ISTG-1]),
         .num_x    (nx10_ff),
         .num_y    (ny10_ff),
         .den_x    (rad_ff),
         .den_y    (rad_ff),
         .side_in  ({c_ff[ISTG-1], rad_bad_ff}),
         .out_valid(dv),
         .quot_x   (dqx),
         .quot_y   (dqy),
         .sat      (dsat),
         .side_out ({dc, dbad})
      );

      always_comb begin
         nc = dc;
         if (!dc.done) begin
            nc.xu   = dqx;
            nc.yu   = dqy;
            nc.f    = dc.f | dsat;
            nc.done = dbad;
         end
      end

      assign itc[gi+1] = nc;
      assign itv[gi+1] = dv;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_load      = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (itv[ITERATIONS]) begin
         if (!out_valid_ff || rsp_ready) begin
            out_load     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= skid_valid_ff ? skid_ff : itc[ITERATIONS];
      end
      if (skid_load) begin
         skid_ff <= itc[ITERATIONS];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_norm_x    = out_ff.xu;
   assign rsp_norm_y    = out_ff.yu;
   assign rsp_saturated = out_ff.f;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry dropped while output stalled");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !skid_valid_ff && !itv[ITERATIONS] |=> !out_valid_ff)
      else $error("output became valid with no finished item");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready && itv[ITERATIONS] && !skid_valid_ff |=> !req_ready)
      else $error("input accepted with both output entries full");

endmodule
`default_nettype wire
